[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define DSW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DSW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DSW_ASSERT(lbl, clk, rst_n, prop, msg)
`define DSW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[sv/dsw_pkg.sv]
// Types, constants and the segment table of the decimal seven-segment writer.
`timescale 1ns / 1ps
package dsw_pkg;

  localparam int VALUE_W         = 27;
  localparam int MAX_DIGITS      = 8;
  localparam int DIGIT_COUNT_DEF = 8;
  localparam int COUNT_W         = 4;
  localparam int IDX_W           = 3;
  localparam int PROD_W          = 2 * VALUE_W;

  localparam logic [VALUE_W-1:0] DIV10_MULT  = VALUE_W'(107374183);
  localparam int                 DIV10_SHIFT = 30;

  localparam logic [7:0] ADDR_FIRST = 8'hCE;

  typedef struct packed {
    logic [VALUE_W-1:0]          rest;
    logic [MAX_DIGITS-1:0][3:0]  digits;
    logic [COUNT_W-1:0]          count;
    logic                        done;
  } stage_t;

  function automatic logic [6:0] seg_of(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

[sv/dsw_digit_stage.sv]
// One pipeline stage: divide the rest by ten and, unless the item is done, record one decimal digit.
`timescale 1ns / 1ps
module dsw_digit_stage
  import dsw_pkg::*;
#(
  parameter int STAGE_IDX = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_vld,
  input  stage_t in_data,
  output logic   out_vld,
  output stage_t out_data
);

  logic               vld_r;
  stage_t             data_r;
  stage_t             data_nxt;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] rem;

  always_comb begin
    prod = PROD_W'(in_data.rest) * PROD_W'(DIV10_MULT);
    quot = VALUE_W'(prod >> DIV10_SHIFT);
    rem  = in_data.rest - ((quot << 3) + (quot << 1));
    data_nxt      = in_data;
    data_nxt.rest = quot;
    if (!in_data.done) begin
      data_nxt.digits[STAGE_IDX] = rem[3:0];
      data_nxt.count             = COUNT_W'(STAGE_IDX + 1);
      data_nxt.done              = (quot == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

[sv/dsw_serializer.sv]
// Output stage: emit the digits of one item, one result per cycle while out_stall is low.
`timescale 1ns / 1ps
module dsw_serializer
  import dsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       src_vld,
  input  stage_t     src_data,
  output logic       load_ok,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_position_address,
  output logic [6:0] out_segment_pattern,
  output logic       out_last_digit
);

  logic                       busy_r;
  logic [IDX_W-1:0]           idx_r;
  logic [MAX_DIGITS-1:0][3:0] digits_r;
  logic [COUNT_W-1:0]         count_r;
  logic                       last;
  logic                       take;

  assign last    = ({1'b0, idx_r} == (count_r - COUNT_W'(1)));
  assign take    = busy_r && !out_stall;
  assign load_ok = !busy_r || (take && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load_ok) begin
      busy_r <= src_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      idx_r    <= '0;
      digits_r <= src_data.digits;
      count_r  <= src_data.count;
    end else if (take) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  assign out_valid            = busy_r;
  assign out_position_address = ADDR_FIRST - 8'({idx_r, 1'b0});
  assign out_segment_pattern  = seg_of(digits_r[idx_r]);
  assign out_last_digit       = last;

endmodule

[sv/decimal_seven_segment_writer.sv]
// Top level of the decimal seven-segment writer.
//
// Input channel: in_value with in_valid / in_stall; an item is taken at a clock
// edge where in_valid is high and in_stall is low. Result channel: one item per
// decimal digit, least significant first, with out_position_address (0xCE for
// the rightmost position, stepping down by two), out_segment_pattern (gfedcba)
// and out_last_digit on the final digit; out_valid / out_stall hand it over.
// Zero gives one digit. Digits beyond DIGIT_COUNT are dropped.
//
// Path: an item that is taken loads into the input register at that edge, then
// passes one divide-by-ten stage per digit (a 27 x 27 reciprocal multiply each),
// then the output register, which shows its first result.
// Throughput: one result per cycle while out_stall is low; an item holds the
// output stage until its last digit is taken, and the next item loads into it
// at that same edge.
// Reset clears all valid bits; no result is pending afterwards.
// While out_stall holds a result, the output stage keeps it, and once the
// last stage also holds a valid item the whole pipeline freezes and
// in_stall rises; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module decimal_seven_segment_writer
  import dsw_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_position_address,
  output logic [6:0]         out_segment_pattern,
  output logic               out_last_digit
);

  localparam int N = (DIGIT_COUNT < 1) ? 1 : ((DIGIT_COUNT > MAX_DIGITS) ? MAX_DIGITS
                                                                       : DIGIT_COUNT);

  logic   adv;
  logic   load_ok;
  logic   vld   [N+1];
  stage_t data  [N+1];
  logic   in_vld_r;
  stage_t in_data_r;

  assign adv      = !vld[N] || load_ok;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_data_r.rest   <= in_value;
      in_data_r.digits <= '0;
      in_data_r.count  <= '0;
      in_data_r.done   <= 1'b0;
    end
  end

  assign vld[0]  = in_vld_r;
  assign data[0] = in_data_r;

  for (genvar k = 0; k < N; k++) begin : g_stage
    dsw_digit_stage #(
      .STAGE_IDX (k)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (vld[k]),
      .in_data  (data[k]),
      .out_vld  (vld[k+1]),
      .out_data (data[k+1])
    );
  end

  dsw_serializer u_ser (
    .clk                  (clk),
    .rst_n                (rst_n),
    .src_vld              (vld[N]),
    .src_data             (data[N]),
    .load_ok              (load_ok),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_position_address (out_position_address),
    .out_segment_pattern  (out_segment_pattern),
    .out_last_digit       (out_last_digit)
  );

  `DSW_ASSERT(a_next_digit, clk, rst_n,
    out_valid && !out_last_digit && !out_stall |=>
      out_valid && out_position_address == $past(out_position_address) - 8'd2,
    "digit step broke")
  `DSW_ASSERT(a_new_item, clk, rst_n,
    out_valid && out_last_digit && !out_stall && vld[N] |=>
      out_valid && out_position_address == ADDR_FIRST,
    "new item not at first position")
  `DSW_ASSERT(a_stall_full, clk, rst_n, in_stall |-> vld[N] && out_valid,
    "stall without pending item")
  `DSW_ASSERT_NEVER(a_addr_range, clk, rst_n,
    out_valid && out_position_address < ADDR_FIRST - 8'(2 * (N - 1)),
    "position beyond digit count")

endmodule
